@@ hw/rtl/uer_pkg.sv @@
// shared types, register indexes and distance arithmetic for the echo ranger
package uer_pkg;

	localparam int unsigned CFG_ADDR_W   = 2;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned TRIG_W       = 10;
	localparam int unsigned TMR_W        = 16;
	localparam int unsigned PULSE_OUT_W  = 17;
	localparam int unsigned DIST_W       = 15;
	localparam int unsigned PULSE_MAX_W  = 24;
	localparam int unsigned IN_TDATA_W   = 8;
	localparam int unsigned OUT_TDATA_W  = 40;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_TRIG_WIDTH = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TMO   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RISE_TMO   = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_FALL_TMO   = 2'd3;

	// reset values
	localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST = 10'd60;
	localparam logic [TMR_W-1:0]  IDLE_TMO_RST   = 16'd2000;
	localparam logic [TMR_W-1:0]  RISE_TMO_RST   = 16'd40000;
	localparam logic [TMR_W-1:0]  FALL_TMO_RST   = 16'd40000;

	// measurement status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_STUCK_HIGH  = 2'd1,
		ST_NO_RISE     = 2'd2,
		ST_NO_FALL     = 2'd3
	} status_t;

	// pulse widths at or above this give a distance beyond 32767 mm
	localparam logic [PULSE_MAX_W-1:0] DIST_SAT_PULSE = 24'd190052;
	localparam logic [DIST_W-1:0]      DIST_SAT_MM    = 15'h7fff;
	// ceil(2^25 / 29), exact for a 20 bit dividend
	localparam logic [20:0]            RECIP_29       = 21'd1157050;

	typedef struct packed {
		logic                   trig_level;
		logic                   busy_res;
		logic                   done_res;
		status_t                status;
		logic [DIST_W-1:0]      distance_mm;
		logic [PULSE_OUT_W-1:0] pulse_ticks;
	} res_t;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} item_t;

	typedef struct packed {
		logic [TRIG_W-1:0] trig_width;
		logic [TMR_W-1:0]  idle_tmo;
		logic [TMR_W-1:0]  rise_tmo;
		logic [TMR_W-1:0]  fall_tmo;
	} cfg_t;

	// (p*10+29)/58, saturated; /58 done as halving then reciprocal multiply by 29
	function automatic logic [DIST_W-1:0] dist_mm(input logic [PULSE_MAX_W-1:0] p);
		logic [20:0] num;
		logic [19:0] half;
		logic [40:0] prod;
		num  = 21'(p[17:0]) * 21'd10 + 21'd29;
		half = num[20:1];
		prod = 41'(half) * 41'(RECIP_29);
		if (p >= DIST_SAT_PULSE) begin
			dist_mm = DIST_SAT_MM;
		end else begin
			dist_mm = prod[39:25];
		end
	endfunction

endpackage

@@ hw/rtl/ultrasonic_echo_ranger_core.sv @@
// top level of the ultrasonic echo ranger: stream ports, config registers, pipeline registers
//
// usage:
//   each input transfer on s_* is one microsecond tick: start_req asks for a
//   measurement, echo_level is the sampled echo pin. every input transfer
//   yields exactly one output transfer on m_* carrying the trigger drive
//   level, busy and done flags, status and, on a successful done tick, the
//   pulse width and the rounded distance in millimetres.
//   configuration goes through cfg_we / cfg_addr / cfg_wdata and is taken at
//   any clock edge with cfg_we high; change it only while no tick is in flight.
//   path: the input transfer lands in the input register, the sequencer
//   logic and distance multiply fill the output register once it is free,
//   and the output register drives m_tvalid and m_tdata until the result
//   transfers. throughput is one tick per cycle while the receiver keeps
//   m_tready high, set by the single pass through the sequencer with no iteration.
//   when the receiver stalls the output register holds its transfer, the
//   input register fills, and s_tready drops; nothing is lost or repeated.
//   reset clears the sequencer to idle, empties both registers and loads the
//   default trigger width and timeouts.
module ultrasonic_echo_ranger_core import uer_pkg::*; #(
	parameter int unsigned PULSE_BITS = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input ticks
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] start_req, [1] echo_level, [7:2] zero
	// results
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] trig_level, [1] busy_res, [2] done_res,
	                                          // [4:3] status, [19:5] distance_mm,
	                                          // [36:20] pulse_ticks, [39:37] zero
	// configuration writes
	input  logic                   cfg_we,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t  cfg_q;
	logic  vld_s1;
	item_t item_s1;
	logic  adv;
	res_t  res;
	res_t  res_q;
	logic  out_vld_q;

	// configuration registers, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_width <= TRIG_WIDTH_RST;
			cfg_q.idle_tmo   <= IDLE_TMO_RST;
			cfg_q.rise_tmo   <= RISE_TMO_RST;
			cfg_q.fall_tmo   <= FALL_TMO_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TRIG_WIDTH: cfg_q.trig_width <= cfg_wdata[TRIG_W-1:0];
				REG_IDLE_TMO:   cfg_q.idle_tmo   <= cfg_wdata;
				REG_RISE_TMO:   cfg_q.rise_tmo   <= cfg_wdata;
				REG_FALL_TMO:   cfg_q.fall_tmo   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// tick moves from the input register into the output register when that is free
	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.start_req  <= s_tdata[0];
			item_s1.echo_level <= s_tdata[1];
		end
	end

	// sequencer advances one tick per transfer into the output register
	uer_fsm #(
		.PULSE_BITS (PULSE_BITS)
	) u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, res_q.pulse_ticks, res_q.distance_mm, res_q.status,
	                   res_q.done_res, res_q.busy_res, res_q.trig_level};

endmodule

@@ hw/rtl/uer_fsm.sv @@
// measurement sequencer: phase state, timers and pulse count, one tick per step
module uer_fsm import uer_pkg::*; #(
	parameter int unsigned PULSE_BITS = 17
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_WAIT_LOW  = 7'b0000010,
		PH_TRIG      = 7'b0000100,
		PH_WAIT_RISE = 7'b0001000,
		PH_WAIT_FALL = 7'b0010000,
		PH_TRIG_DONE = 7'b0100000,
		PH_REPORT    = 7'b1000000
	} phase_t;

	localparam logic [PULSE_BITS-1:0] PULSE_SAT = {PULSE_BITS{1'b1}};

	phase_t                phase_q, phase_d;
	logic [TMR_W-1:0]      tmr_q, tmr_d;
	logic [PULSE_BITS-1:0] pulse_q, pulse_d;
	logic                  rise_q, rise_d;

	logic [TMR_W-1:0]      idle_lim, rise_lim, fall_lim;
	logic [TRIG_W-1:0]     width;
	logic [TMR_W:0]        tmr_inc;
	logic [TMR_W-1:0]      trig_tmr;
	logic [PULSE_BITS-1:0] pulse_inc;
	logic [DIST_W-1:0]     dist_val;
	phase_t                trig_ph;
	logic                  trig_rise;
	logic [PULSE_BITS-1:0] trig_pulse;

	assign idle_lim  = (cfg.idle_tmo == '0) ? TMR_W'(1) : cfg.idle_tmo;
	assign rise_lim  = (cfg.rise_tmo == '0) ? TMR_W'(1) : cfg.rise_tmo;
	assign fall_lim  = (cfg.fall_tmo == '0) ? TMR_W'(1) : cfg.fall_tmo;
	assign width     = (cfg.trig_width == '0) ? TRIG_W'(1) : cfg.trig_width;
	assign tmr_inc   = {1'b0, tmr_q} + 1'b1;
	assign trig_tmr  = tmr_inc[TMR_W-1:0];
	assign pulse_inc = (pulse_q < PULSE_SAT) ? pulse_q + 1'b1 : pulse_q;
	assign dist_val  = dist_mm(PULSE_MAX_W'(pulse_q));

	always_comb begin
		phase_d    = phase_q;
		tmr_d      = tmr_q;
		pulse_d    = pulse_q;
		rise_d     = rise_q;
		trig_ph    = phase_q;
		trig_rise  = rise_q;
		trig_pulse = pulse_q;
		res             = '0;
		res.status      = ST_OK;
		res.busy_res    = 1'b1;
		case (phase_q)
			PH_IDLE: begin
				if (item.start_req) begin
					phase_d = PH_WAIT_LOW;
					tmr_d   = '0;
				end else begin
					res.busy_res = 1'b0;
				end
			end
			PH_WAIT_LOW: begin
				if (!item.echo_level) begin
					phase_d = PH_TRIG;
					tmr_d   = '0;
					rise_d  = 1'b0;
					pulse_d = '0;
				end else if (tmr_inc >= {1'b0, idle_lim}) begin
					res.busy_res = 1'b0;
					res.done_res = 1'b1;
					res.status   = ST_STUCK_HIGH;
					phase_d      = PH_IDLE;
					tmr_d        = '0;
				end else begin
					tmr_d = trig_tmr;
				end
			end
			PH_TRIG, PH_TRIG_DONE: begin
				res.trig_level = 1'b1;
				// capture only while the pulse has not ended
				if (phase_q == PH_TRIG) begin
					if (!rise_q) begin
						if (item.echo_level) begin
							trig_rise  = 1'b1;
							trig_pulse = PULSE_BITS'(1);
						end
					end else if (item.echo_level) begin
						trig_pulse = pulse_inc;
					end else begin
						trig_ph = PH_TRIG_DONE;
					end
				end
				rise_d  = trig_rise;
				pulse_d = trig_pulse;
				if (trig_tmr >= TMR_W'(width)) begin
					tmr_d = '0;
					if (trig_ph == PH_TRIG_DONE) begin
						phase_d = PH_REPORT;
					end else if (trig_rise) begin
						phase_d = PH_WAIT_FALL;
					end else begin
						phase_d = PH_WAIT_RISE;
					end
				end else begin
					tmr_d   = trig_tmr;
					phase_d = trig_ph;
				end
			end
			PH_WAIT_RISE: begin
				if (item.echo_level) begin
					rise_d  = 1'b1;
					pulse_d = PULSE_BITS'(1);
					phase_d = PH_WAIT_FALL;
					tmr_d   = '0;
				end else if (tmr_inc >= {1'b0, rise_lim}) begin
					res.busy_res = 1'b0;
					res.done_res = 1'b1;
					res.status   = ST_NO_RISE;
					phase_d      = PH_IDLE;
					tmr_d        = '0;
				end else begin
					tmr_d = trig_tmr;
				end
			end
			PH_WAIT_FALL: begin
				if (!item.echo_level) begin
					res.busy_res    = 1'b0;
					res.done_res    = 1'b1;
					res.distance_mm = dist_val;
					res.pulse_ticks = PULSE_OUT_W'({{PULSE_MAX_W{1'b0}}, pulse_q});
					phase_d         = PH_IDLE;
					tmr_d           = '0;
				end else begin
					pulse_d = pulse_inc;
					if (tmr_inc >= {1'b0, fall_lim}) begin
						res.busy_res = 1'b0;
						res.done_res = 1'b1;
						res.status   = ST_NO_FALL;
						phase_d      = PH_IDLE;
						tmr_d        = '0;
					end else begin
						tmr_d = trig_tmr;
					end
				end
			end
			PH_REPORT: begin
				res.busy_res    = 1'b0;
				res.done_res    = 1'b1;
				res.distance_mm = dist_val;
				res.pulse_ticks = PULSE_OUT_W'({{PULSE_MAX_W{1'b0}}, pulse_q});
				phase_d         = PH_IDLE;
				tmr_d           = '0;
			end
			default: begin
				res.busy_res = 1'b0;
				phase_d      = PH_IDLE;
				tmr_d        = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tmr_q   <= '0;
			pulse_q <= '0;
			rise_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tmr_q   <= tmr_d;
			pulse_q <= pulse_d;
			rise_q  <= rise_d;
		end
	end

endmodule
